### rtl/per_device_sequential_io_classifier_assert.svh
// Assertion macros shared by the per-device I/O classifier RTL.
// Needs nothing else; each macro checks on the rising clock edge and stays quiet in reset.
`ifndef PER_DEVICE_SEQUENTIAL_IO_CLASSIFIER_ASSERT_SVH
`define PER_DEVICE_SEQUENTIAL_IO_CLASSIFIER_ASSERT_SVH

// Property must hold at every edge outside reset.
`define PCLS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define PCLS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/pcls_pkg.sv
// Shared types and constants for the per-device sequential I/O classifier.
// No dependencies; the classifier modules and the testbench refer to it by scoped names.
package pcls_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW         = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW         = $clog2(TableEntries + 1);
  localparam int unsigned SectorShift  = 9;

  typedef enum logic [2:0] {
    StSequential = 3'd0,
    StRandom     = 3'd1,
    StFirst      = 3'd2,
    StFiltered   = 3'd3,
    StFull       = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CfgFilterEnable = 1'b0,
    CfgTargetDevice = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FsmIdle,
    FsmScan,
    FsmUpdate
  } fsm_e;

  // One table entry as stored in the data memory.
  typedef struct packed {
    logic [63:0] end_sector;
    logic [31:0] seq_cnt;
    logic [31:0] rnd_cnt;
    logic [63:0] bytes;
  } entry_t;

  // Control for the update step.
  typedef struct packed {
    logic    skip;
    logic    is_new;
    status_e skip_status;
  } ctl_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] seq_total;
    logic [31:0] rnd_total;
    logic [63:0] byte_total;
  } result_t;

endpackage

### rtl/pcls_req_if.sv
// Request channel of the classifier: one completed block request per transaction.
// Standalone valid/ready interface; no package needed.
interface pcls_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] device;
  logic [63:0] start_sector;
  logic [31:0] sector_count;

  modport source (output valid, output device, output start_sector, output sector_count,
                  input ready);
  modport sink   (input valid, input device, input start_sector, input sector_count,
                  output ready);
endinterface

### rtl/pcls_rsp_if.sv
// Result channel of the classifier: status and the device's counters per transaction.
// Standalone valid/ready interface; no package needed.
interface pcls_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] sequential_total;
  logic [31:0] random_total;
  logic [63:0] byte_total;

  modport source (output valid, output status, output sequential_total,
                  output random_total, output byte_total, input ready);
  modport sink   (input valid, input status, input sequential_total,
                  input random_total, input byte_total, output ready);
endinterface

### rtl/pcls_classify.sv
// Update datapath: classifies one request against its table entry.
// Depends on pcls_pkg for the entry, control and result types.
module pcls_classify (
  input  pcls_pkg::entry_t  entry_i,
  input  pcls_pkg::ctl_t    ctl_i,
  input  logic [63:0]       start_sector_i,
  input  logic [31:0]       sector_count_i,
  output pcls_pkg::entry_t  entry_o,
  output pcls_pkg::result_t result_o
);

  pcls_pkg::entry_t cur;
  logic [31:0]      byte_inc;

  assign byte_inc = sector_count_i << pcls_pkg::SectorShift;

  always_comb begin
    cur     = ctl_i.is_new ? '0 : entry_i;
    entry_o = cur;
    result_o.status = pcls_pkg::StFirst;
    if (cur.end_sector != 64'd0) begin
      if (cur.end_sector == start_sector_i) begin
        entry_o.seq_cnt = cur.seq_cnt + 32'd1;
        result_o.status = pcls_pkg::StSequential;
      end else begin
        entry_o.rnd_cnt = cur.rnd_cnt + 32'd1;
        result_o.status = pcls_pkg::StRandom;
      end
      entry_o.bytes = cur.bytes + {32'd0, byte_inc};
    end
    entry_o.end_sector = start_sector_i + {32'd0, sector_count_i};

    result_o.seq_total  = entry_o.seq_cnt;
    result_o.rnd_total  = entry_o.rnd_cnt;
    result_o.byte_total = entry_o.bytes;
    // Filtered and full requests report zero counters.
    if (ctl_i.skip) begin
      result_o.status     = ctl_i.skip_status;
      result_o.seq_total  = 32'd0;
      result_o.rnd_total  = 32'd0;
      result_o.byte_total = 64'd0;
    end
  end

endmodule

### rtl/per_device_sequential_io_classifier.sv
// Per-device sequential I/O classifier, top level.
// Depends on pcls_pkg, pcls_req_if, pcls_rsp_if, pcls_classify and the assertion header.
//
// Usage:
//   req_i carries one completed block request per transaction (device, start
//   sector, sector count); rsp_o returns exactly one result per request: the
//   status and the device's updated sequential, random and byte counters.
//   The config port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes filter_enable
//   and target_device; write it only while no request is in flight.
// Flow:
//   Devices sit in a device-key memory filled in order of first appearance;
//   a request scans it one entry per cycle (a filtered request skips the scan),
//   up to fill entries, fill being the number of devices seen so far (at most
//   64). Then one read-modify-write of the entry's data memory closes the
//   request and the result lands in the output register; one request is in
//   work at a time.
// Reset:
//   Clears the config registers, the fill count and all handshake state. The
//   memories keep their contents; entries at or above the fill count are
//   never read, so no clearing pass is needed.
// Stalls:
//   A result waits in the output register; the next request is still accepted
//   and worked on, and its result holds in the update step until the output
//   register frees up.
`include "per_device_sequential_io_classifier_assert.svh"

module per_device_sequential_io_classifier (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  pcls_req_if.sink           req_i,
  pcls_rsp_if.source         rsp_o
);

  // Configuration registers.
  logic        filter_en_q;
  logic [31:0] target_dev_q;

  // Latched request (payload, no reset).
  logic [31:0] dev_q;
  logic [63:0] start_q;
  logic [31:0] count_q;

  // Control state.
  pcls_pkg::fsm_e state_q, state_d;
  logic [pcls_pkg::CntW-1:0] scan_q;
  logic [pcls_pkg::CntW-1:0] fill_q;
  logic                      rd_vld_q;
  logic [pcls_pkg::IdxW-1:0] rd_idx_q;
  logic [pcls_pkg::IdxW-1:0] slot_q;
  pcls_pkg::ctl_t            ctl_q;

  // Output register.
  logic              rsp_valid_q;
  pcls_pkg::result_t result_q;

  // Memories: device keys and entry data, both with registered (synchronous) reads.
  logic [31:0]      dev_mem  [pcls_pkg::TableEntries];
  pcls_pkg::entry_t data_mem [pcls_pkg::TableEntries];
  logic [31:0]      dev_rdata_q;
  pcls_pkg::entry_t data_rdata_q;

  // Handshake and control decode.
  logic req_fire;
  logic filtered;
  logic hit;
  logic scan_end;
  logic table_full;
  logic out_free;
  logic commit;
  logic dev_re;
  logic data_re;
  logic mem_we;

  pcls_pkg::entry_t  entry_new;
  pcls_pkg::result_t result_new;

  assign req_fire   = req_i.valid && req_i.ready;
  assign filtered   = filter_en_q && (target_dev_q != req_i.device);
  // Keys are unique, so the first matching read is the device's slot.
  assign hit        = rd_vld_q && (dev_rdata_q == dev_q);
  assign scan_end   = (scan_q == fill_q);
  assign table_full = (fill_q == pcls_pkg::CntW'(pcls_pkg::TableEntries));
  assign out_free   = !rsp_valid_q || rsp_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcls_pkg::FsmIdle: begin
        if (req_fire) begin
          state_d = filtered ? pcls_pkg::FsmUpdate : pcls_pkg::FsmScan;
        end
      end
      pcls_pkg::FsmScan: begin
        if (hit || scan_end) begin
          state_d = pcls_pkg::FsmUpdate;
        end
      end
      pcls_pkg::FsmUpdate: begin
        if (out_free) begin
          state_d = pcls_pkg::FsmIdle;
        end
      end
      default: state_d = pcls_pkg::FsmIdle;
    endcase
  end

  // State outputs.
  always_comb begin
    req_i.ready = 1'b0;
    dev_re      = 1'b0;
    data_re     = 1'b0;
    commit      = 1'b0;
    unique case (state_q)
      pcls_pkg::FsmIdle: begin
        req_i.ready = 1'b1;
      end
      pcls_pkg::FsmScan: begin
        dev_re  = !hit && !scan_end;
        data_re = hit;
      end
      pcls_pkg::FsmUpdate: begin
        commit = out_free;
      end
      default: ;
    endcase
  end

  assign mem_we = commit && !ctl_q.skip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcls_pkg::FsmIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Config writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q  <= 1'b0;
      target_dev_q <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (pcls_pkg::cfg_reg_e'(cfg_idx_i))
        pcls_pkg::CfgFilterEnable: filter_en_q  <= cfg_wdata_i[0];
        pcls_pkg::CfgTargetDevice: target_dev_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Hold the accepted request.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      dev_q   <= req_i.device;
      start_q <= req_i.start_sector;
      count_q <= req_i.sector_count;
    end
  end

  // Scan, slot selection and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      fill_q   <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      slot_q   <= '0;
      ctl_q    <= '{skip: 1'b0, is_new: 1'b0, skip_status: pcls_pkg::StFiltered};
    end else begin
      if (req_fire) begin
        scan_q   <= '0;
        rd_vld_q <= 1'b0;
        ctl_q    <= '{skip: filtered, is_new: 1'b0, skip_status: pcls_pkg::StFiltered};
      end
      if (state_q == pcls_pkg::FsmScan) begin
        rd_vld_q <= dev_re;
        if (dev_re) begin
          rd_idx_q <= scan_q[pcls_pkg::IdxW-1:0];
          scan_q   <= scan_q + pcls_pkg::CntW'(1);
        end
        if (hit) begin
          slot_q <= rd_idx_q;
        end else if (scan_end) begin
          // Unseen device: allocate the next free slot, or drop when full.
          if (table_full) begin
            ctl_q <= '{skip: 1'b1, is_new: 1'b0, skip_status: pcls_pkg::StFull};
          end else begin
            slot_q       <= fill_q[pcls_pkg::IdxW-1:0];
            ctl_q.is_new <= 1'b1;
          end
        end
      end
      if (mem_we && ctl_q.is_new) begin
        fill_q <= fill_q + pcls_pkg::CntW'(1);
      end
    end
  end

  // Memories. The entry read in the scan step is written back in the update
  // step, and the next request reads only after that, so no forwarding.
  always_ff @(posedge clk_i) begin
    if (dev_re) begin
      dev_rdata_q <= dev_mem[scan_q[pcls_pkg::IdxW-1:0]];
    end
    if (mem_we && ctl_q.is_new) begin
      dev_mem[slot_q] <= dev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_re) begin
      data_rdata_q <= data_mem[rd_idx_q];
    end
    if (mem_we) begin
      data_mem[slot_q] <= entry_new;
    end
  end

  pcls_classify u_classify (
    .entry_i        (data_rdata_q),
    .ctl_i          (ctl_q),
    .start_sector_i (start_q),
    .sector_count_i (count_q),
    .entry_o        (entry_new),
    .result_o       (result_new)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      result_q <= result_new;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.status           = result_q.status;
  assign rsp_o.sequential_total = result_q.seq_total;
  assign rsp_o.random_total     = result_q.rnd_total;
  assign rsp_o.byte_total       = result_q.byte_total;

  // Checks.
  `PCLS_ASSERT(a_fill_bound, clk_i, rst_ni,
    fill_q <= pcls_pkg::CntW'(pcls_pkg::TableEntries), "fill count beyond table size")
  `PCLS_ASSERT(a_scan_bound, clk_i, rst_ni,
    (state_q == pcls_pkg::FsmScan) |-> (scan_q <= fill_q), "scan ran past fill count")
  `PCLS_ASSERT(a_fill_on_alloc, clk_i, rst_ni,
    (fill_q != $past(fill_q)) |-> $past(mem_we && ctl_q.is_new), "fill moved without allocation")
  `PCLS_ASSERT(a_rsp_from_update, clk_i, rst_ni,
    $rose(rsp_valid_q) |-> $past(state_q == pcls_pkg::FsmUpdate), "result without update step")
  `PCLS_ASSERT_NEVER(a_read_write_clash, clk_i, rst_ni,
    data_re && mem_we, "entry read and write in one cycle")

endmodule

### test/per_device_sequential_io_classifier_tb.sv
// Testbench for the per-device sequential I/O classifier: directed table, then random phases.
// Needs pcls_pkg, pcls_req_if, pcls_rsp_if and the classifier RTL; no files or arguments.
`timescale 1ns / 1ps

module per_device_sequential_io_classifier_tb;

  localparam int CycleLimit  = 600000;
  // Worst-case scan of a full table plus the update and output stages.
  localparam int DrainCycles = pcls_pkg::TableEntries + 16;

  typedef enum logic [1:0] {
    RowRequest,   // request checked against the predictor
    RowChecked,   // request with the expected result typed in
    RowProgram    // write both filter registers
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic              fe;
    logic [31:0]       tgt;
    logic [31:0]       dev;
    logic [63:0]       start;
    logic [31:0]       count;
    pcls_pkg::result_t res;
  } stim_row_t;

  // Clock, reset and every block input start at known values.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we      = 1'b0;
  pcls_pkg::cfg_reg_e cfg_idx     = pcls_pkg::CfgFilterEnable;
  logic [31:0]        cfg_wdata   = '0;
  logic               src_valid   = 1'b0;
  logic [31:0]        src_device  = '0;
  logic [63:0]        src_start   = '0;
  logic [31:0]        src_count   = '0;
  logic               sink_ready  = 1'b0;

  pcls_req_if req_if ();
  pcls_rsp_if rsp_if ();

  assign req_if.valid        = src_valid;
  assign req_if.device       = src_device;
  assign req_if.start_sector = src_start;
  assign req_if.sector_count = src_count;
  assign rsp_if.ready        = sink_ready;

  per_device_sequential_io_classifier u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Device table predictor: its own copy of the filter registers and entries.
  // ---------------------------------------------------------------------------
  logic        flt_enable = 1'b0;
  logic [31:0] flt_target = '0;
  bit          model_used   [pcls_pkg::TableEntries];
  logic [31:0] model_key    [pcls_pkg::TableEntries];
  logic [63:0] model_end    [pcls_pkg::TableEntries];
  logic [31:0] model_seq    [pcls_pkg::TableEntries];
  logic [31:0] model_rnd    [pcls_pkg::TableEntries];
  logic [63:0] model_bytes  [pcls_pkg::TableEntries];

  // Classifier results still owed by the block, oldest first.
  pcls_pkg::result_t pending_results [$];

  int                error_count  = 0;
  int                results_seen = 0;
  int                cycle_count  = 0;
  pcls_pkg::result_t expected_head;

  function automatic int find_entry(input logic [31:0] dev);
    for (int i = 0; i < pcls_pkg::TableEntries; i++) begin
      if (model_used[i] && model_key[i] == dev) return i;
    end
    return -1;
  endfunction

  // Classify one accepted request and advance the table state.
  function automatic void predict_classification(input logic [31:0] dev,
                                                 input logic [63:0] start,
                                                 input logic [31:0] count,
                                                 output pcls_pkg::result_t res);
    int          slot;
    logic [31:0] scaled;
    res = '0;
    if (flt_enable && flt_target != dev) begin
      res.status = pcls_pkg::StFiltered;
      return;
    end
    slot = find_entry(dev);
    if (slot < 0) begin
      // Allocate the lowest free slot with cleared counters.
      for (int i = 0; i < pcls_pkg::TableEntries; i++) begin
        if (!model_used[i] && slot < 0) slot = i;
      end
      if (slot < 0) begin
        res.status = pcls_pkg::StFull;
        return;
      end
      model_used[slot]  = 1'b1;
      model_key[slot]   = dev;
      model_end[slot]   = '0;
      model_seq[slot]   = '0;
      model_rnd[slot]   = '0;
      model_bytes[slot] = '0;
    end
    // A zero end sector means no previous request to compare against.
    if (model_end[slot] != '0) begin
      if (model_end[slot] == start) begin
        model_seq[slot] = model_seq[slot] + 32'd1;
        res.status = pcls_pkg::StSequential;
      end else begin
        model_rnd[slot] = model_rnd[slot] + 32'd1;
        res.status = pcls_pkg::StRandom;
      end
      // The shifted count wraps at 32 bits before it is added.
      scaled = count << pcls_pkg::SectorShift;
      model_bytes[slot] = model_bytes[slot] + {32'd0, scaled};
    end else begin
      res.status = pcls_pkg::StFirst;
    end
    model_end[slot]  = start + {32'd0, count};
    res.seq_total    = model_seq[slot];
    res.rnd_total    = model_rnd[slot];
    res.byte_total   = model_bytes[slot];
  endfunction

  function automatic logic [63:0] stored_end(input logic [31:0] dev);
    int slot;
    slot = find_entry(dev);
    return (slot < 0) ? 64'd0 : model_end[slot];
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall on a 32-bit ready pattern that is redrawn each lap.
  // ---------------------------------------------------------------------------
  logic [31:0] ready_pattern = '1;
  logic [4:0]  stall_phase   = '0;

  always @(posedge clk_i) begin
    sink_ready  <= ready_pattern[stall_phase];
    stall_phase <= stall_phase + 5'd1;
    if (stall_phase == 5'd31) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern <= '1;                   // stretch with no stalls
        1:       ready_pattern <= $urandom;
        2:       ready_pattern <= $urandom | $urandom;  // light stalls
        default: ready_pattern <= $urandom & $urandom;  // heavy stalls
      endcase
    end
  end

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      if (error_count < 10)
        $display("result %0d: %s expected %h, got %h", results_seen, field, want, got);
      error_count++;
    end
  endtask

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        if (error_count < 10)
          $display("result %0d arrived with nothing expected", results_seen);
        error_count++;
      end else begin
        expected_head = pending_results.pop_front();
        check_field("status", 64'(expected_head.status), 64'(rsp_if.status));
        check_field("sequential_total", 64'(expected_head.seq_total),
                    64'(rsp_if.sequential_total));
        check_field("random_total", 64'(expected_head.rnd_total),
                    64'(rsp_if.random_total));
        check_field("byte_total", expected_head.byte_total, rsp_if.byte_total);
      end
      results_seen++;
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("FAIL per_device_sequential_io_classifier");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------------
  bit valid_held = 1'b0;
  int burst_left = 4;

  // Present one request, hold it until the handshake, then queue its result.
  task automatic send_request(input logic [31:0] dev, input logic [63:0] start,
                              input logic [31:0] count, input bit typed,
                              input pcls_pkg::result_t typed_res);
    pcls_pkg::result_t predicted;
    src_valid  <= 1'b1;
    src_device <= dev;
    src_start  <= start;
    src_count  <= count;
    valid_held = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    // The transaction went through at this edge: advance the predictor.
    predict_classification(dev, start, count, predicted);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // End the burst when it runs out and idle for a random gap.
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      src_valid <= 1'b0;
      valid_held = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  // Drop valid, wait for every owed result and let the scan pipeline empty.
  task automatic settle_idle();
    if (valid_held) begin
      src_valid <= 1'b0;
      valid_held = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write both filter registers on back-to-back edges; write enable stays high between.
  task automatic program_filter(input logic fe, input logic [31:0] tgt);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= pcls_pkg::CfgFilterEnable;
    cfg_wdata <= {31'd0, fe};
    @(posedge clk_i);
    flt_enable = fe;
    cfg_idx   <= pcls_pkg::CfgTargetDevice;
    cfg_wdata <= tgt;
    @(posedge clk_i);
    flt_target = tgt;
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table.
  // ---------------------------------------------------------------------------
  stim_row_t   directed_rows [$];
  logic [31:0] device_pool [8];

  function automatic pcls_pkg::result_t typed_result(input pcls_pkg::status_e st,
                                                     input logic [31:0] s,
                                                     input logic [31:0] r,
                                                     input logic [63:0] b);
    pcls_pkg::result_t res;
    res.status     = st;
    res.seq_total  = s;
    res.rnd_total  = r;
    res.byte_total = b;
    return res;
  endfunction

  task automatic row_req(input logic [31:0] dev, input logic [63:0] start,
                         input logic [31:0] count);
    stim_row_t row;
    row = '{kind: RowRequest, fe: 1'b0, tgt: '0, dev: dev, start: start, count: count,
            res: '0};
    directed_rows.push_back(row);
  endtask

  task automatic row_typed(input logic [31:0] dev, input logic [63:0] start,
                           input logic [31:0] count, input pcls_pkg::result_t res);
    stim_row_t row;
    row = '{kind: RowChecked, fe: 1'b0, tgt: '0, dev: dev, start: start, count: count,
            res: res};
    directed_rows.push_back(row);
  endtask

  task automatic row_cfg(input logic fe, input logic [31:0] tgt);
    stim_row_t row;
    row = '{kind: RowProgram, fe: fe, tgt: tgt, dev: '0, start: '0, count: '0, res: '0};
    directed_rows.push_back(row);
  endtask

  function automatic logic [31:0] fresh_device();
    logic [31:0] d;
    bit          taken;
    do begin
      d = $urandom;
      taken = (find_entry(d) >= 0);
      foreach (device_pool[i]) if (device_pool[i] == d) taken = 1'b1;
    end while (taken);
    return d;
  endfunction

  // Random requests under the current filter setting. Most requests continue the
  // device's last run so sequential hits dominate; the rest are jumps, wraps to a
  // zero end sector and noise. fresh_pct of the unfiltered requests use unseen
  // devices, which fill the table and then hit the full case.
  task automatic run_phase(input int n, input int fresh_pct);
    logic [31:0]       dev;
    logic [63:0]       start;
    logic [31:0]       count;
    logic [63:0]       last_end;
    int                pick;
    int                wrap;
    pcls_pkg::result_t none;
    none = '0;
    for (int k = 0; k < n; k++) begin
      if (flt_enable)
        dev = ($urandom_range(0, 99) < 70) ? flt_target : $urandom;
      else if ($urandom_range(0, 99) < fresh_pct)
        dev = fresh_device();
      else
        dev = device_pool[$urandom_range(0, 7)];

      last_end = stored_end(dev);
      pick = $urandom_range(0, 99);
      wrap = 0;
      if (pick < 60)
        start = (last_end != '0) ? last_end : {$urandom, $urandom};
      else if (pick < 68) begin
        // Land the end sector exactly on zero.
        wrap  = $urandom_range(1, 4);
        start = 64'd0 - 64'(wrap);
      end else if (pick < 74)
        start = '0;
      else
        start = {$urandom, $urandom};

      pick = $urandom_range(0, 99);
      if (wrap != 0)
        count = wrap;
      else if (pick < 55)
        count = $urandom_range(1, 256);
      else if (pick < 65)
        count = '0;
      else if (pick < 75)
        count = '1;
      else
        count = $urandom;

      send_request(dev, start, count, 1'b0, none);
      pace_sender();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    // Keep a small device set so most requests hit known entries; include the extremes.
    device_pool[0] = 32'd0;
    device_pool[1] = 32'd1;
    device_pool[2] = 32'hFFFF_FFFF;
    for (int i = 3; i < 8; i++) device_pool[i] = $urandom;

    // New device, then a run that continues it and a jump back.
    row_typed(32'd1, 64'd100, 32'd8, typed_result(pcls_pkg::StFirst, 0, 0, 0));
    row_typed(32'd1, 64'd108, 32'd8, typed_result(pcls_pkg::StSequential, 1, 0, 64'd4096));
    row_typed(32'd1, 64'd5, 32'd0, typed_result(pcls_pkg::StRandom, 1, 1, 64'd4096));
    // Largest count: the shifted byte increment wraps at 32 bits.
    row_req(32'd1, 64'd5, 32'hFFFF_FFFF);
    // Top device and top sector: the end sector wraps to zero.
    row_typed(32'hFFFF_FFFF, '1, 32'd1, typed_result(pcls_pkg::StFirst, 0, 0, 0));
    row_typed(32'hFFFF_FFFF, 64'd0, 32'd2, typed_result(pcls_pkg::StFirst, 0, 0, 0));
    // Count of 2^23 sectors adds exactly zero bytes.
    row_req(32'hFFFF_FFFF, 64'd2, 32'h0080_0000);
    row_typed(32'd0, 64'd0, 32'd0, typed_result(pcls_pkg::StFirst, 0, 0, 0));
    row_typed(32'd0, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA,
              typed_result(pcls_pkg::StFirst, 0, 0, 0));
    row_req(32'd0, 64'hAAAA_AAAA_AAAA_AAAA, 32'd5);
    row_req(32'd0, 64'hAAAA_AAAA_AAAA_AAAF, 32'h8000_0000);
    // Filter on the top device.
    row_cfg(1'b1, 32'hFFFF_FFFF);
    row_typed(32'd1, 64'd7, 32'd7, typed_result(pcls_pkg::StFiltered, 0, 0, 0));
    row_typed(32'd0, 64'd0, 32'd1, typed_result(pcls_pkg::StFiltered, 0, 0, 0));
    row_req(32'hFFFF_FFFF, 64'h0080_0002, 32'd1);
    row_typed(32'hFFFF_FFFE, 64'd0, 32'd0, typed_result(pcls_pkg::StFiltered, 0, 0, 0));
    // Filter on device zero.
    row_cfg(1'b1, 32'd0);
    row_req(32'd0, 64'h2AAA_AAAA_AAAA_AAAF, 32'd3);
    row_typed(32'hFFFF_FFFF, 64'd1, 32'd1, typed_result(pcls_pkg::StFiltered, 0, 0, 0));
    // Filter off with a target still set: nothing is filtered.
    row_cfg(1'b0, 32'hFFFF_FFFF);
    row_typed(32'hFFFF_FFFE, 64'd1, 32'd1, typed_result(pcls_pkg::StFirst, 0, 0, 0));

    // Hold reset, then release it on an edge.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowProgram)
        program_filter(directed_rows[i].fe, directed_rows[i].tgt);
      else begin
        send_request(directed_rows[i].dev, directed_rows[i].start, directed_rows[i].count,
                     directed_rows[i].kind == RowChecked, directed_rows[i].res);
        pace_sender();
      end
    end

    // Random phases over several filter settings, extremes included.
    program_filter(1'b0, 32'd0);
    run_phase(200, 0);
    program_filter(1'b1, device_pool[4]);
    run_phase(120, 0);
    program_filter(1'b1, 32'hFFFF_FFFF);
    run_phase(80, 0);
    program_filter(1'b0, $urandom);
    run_phase(150, 0);
    // Flood with unseen devices until the table is full, then keep hitting it.
    program_filter(1'b0, 32'd0);
    run_phase(160, 60);
    // Target an unseen device once the table is full.
    program_filter(1'b1, fresh_device());
    run_phase(60, 0);
    program_filter(1'b1, 32'd0);
    run_phase(60, 0);
    program_filter(1'b0, 32'hFFFF_FFFF);
    run_phase(80, 30);

    // Drain everything owed, then watch a while for stray results.
    if (valid_held) begin
      src_valid <= 1'b0;
      valid_held = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS per_device_sequential_io_classifier");
    end else begin
      $display("FAIL per_device_sequential_io_classifier");
    end
    $finish;
  end

endmodule
